// ----- hdl/morse_key_decoder_core_assert.svh -----
// Assertion macros for the Morse key decoder checker
`ifndef MORSE_KEY_DECODER_CORE_ASSERT_SVH
`define MORSE_KEY_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define MKD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define MKD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/mkd_pkg.sv -----
// Shared types, constants and letter table for the Morse key decoder
package mkd_pkg;

  // Fixed field and register widths
  localparam int CfgWidth     = 10;
  localparam int CfgIdxWidth  = 2;
  localparam int KindWidth    = 2;
  localparam int LetterWidth  = 5;
  localparam int HeldWidth    = 3;
  localparam int MaxSymbols   = 4;
  localparam int NumLetters   = 26;
  localparam int DefCountWidth = 10;

  // Event queue between front and back
  localparam int QueueDepth   = 4;
  localparam int QPtrWidth    = $clog2(QueueDepth);
  localparam int QCntWidth    = $clog2(QueueDepth + 1);

  // Register indexes
  localparam logic [CfgIdxWidth-1:0] REG_DOT_MAX    = 2'd0;
  localparam logic [CfgIdxWidth-1:0] REG_LONG_PRESS = 2'd1;
  localparam logic [CfgIdxWidth-1:0] REG_GAP        = 2'd2;

  // Register reset values
  localparam logic [CfgWidth-1:0] DOT_MAX_RESET    = 10'd249;
  localparam logic [CfgWidth-1:0] LONG_PRESS_RESET = 10'd700;
  localparam logic [CfgWidth-1:0] GAP_RESET        = 10'd700;

  // Event kinds
  localparam logic [KindWidth-1:0] EV_SYMBOL   = 2'd0;
  localparam logic [KindWidth-1:0] EV_LETTER   = 2'd1;
  localparam logic [KindWidth-1:0] EV_UNKNOWN  = 2'd2;
  localparam logic [KindWidth-1:0] EV_TOO_LONG = 2'd3;

  // Letter codes: {length, pattern}, pattern bit i set = symbol i is a dash
  localparam logic [6:0] LETTER_CODE [NumLetters] = '{
    7'h22, 7'h41, 7'h45, 7'h31, 7'h10, 7'h44, 7'h33, 7'h40, 7'h20, 7'h4E,
    7'h35, 7'h42, 7'h23, 7'h21, 7'h37, 7'h46, 7'h4B, 7'h32, 7'h30, 7'h11,
    7'h34, 7'h48, 7'h36, 7'h49, 7'h4D, 7'h43
  };

  // Classified event handed from front to back
  typedef struct packed {
    logic [KindWidth-1:0]  kind;    // EV_LETTER here means "decode request"
    logic                  dash;
    logic [HeldWidth-1:0]  held;    // code length for a decode request
    logic [MaxSymbols-1:0] bits;    // code pattern for a decode request
    logic                  ovf;     // code overflowed, decodes as unknown
    logic [HeldWidth-1:0]  count;   // symbols held after the event
  } mkd_ev_t;

endpackage

// ----- hdl/mkd_front.sv -----
// Front end: key timing, symbol collection and event classification
module mkd_front import mkd_pkg::*; #(
  parameter int COUNT_WIDTH = DefCountWidth
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   key_level_i,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxWidth-1:0] cfg_index_i,
  input  logic [CfgWidth-1:0]    cfg_data_i,
  input  logic                   q_full_i,
  output logic                   push_o,
  output mkd_ev_t                ev_o
);

  localparam int CmpWidth = (COUNT_WIDTH > CfgWidth) ? COUNT_WIDTH : CfgWidth;
  localparam logic [COUNT_WIDTH-1:0] CntMax = '1;

  logic [CfgWidth-1:0]    dot_max_q, long_press_q, gap_ticks_q;
  logic                   was_down_q, was_down_d;
  logic [COUNT_WIDTH-1:0] press_q, press_d;
  logic [COUNT_WIDTH-1:0] gap_q, gap_d, gap_inc;
  logic [MaxSymbols-1:0]  bits_q, bits_d;
  logic [HeldWidth-1:0]   held_q, held_d;
  logic                   ovf_q, ovf_d;
  logic                   accept;
  logic                   dash;
  logic [CmpWidth-1:0]    dur_x, gap_x;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_max_q    <= DOT_MAX_RESET;
      long_press_q <= LONG_PRESS_RESET;
      gap_ticks_q  <= GAP_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_DOT_MAX:    dot_max_q    <= cfg_data_i;
        REG_LONG_PRESS: long_press_q <= cfg_data_i;
        REG_GAP:        gap_ticks_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign dur_x   = CmpWidth'(press_q);
  assign gap_inc = (gap_q < CntMax) ? gap_q + 1'b1 : gap_q;
  assign gap_x   = CmpWidth'(gap_inc);
  assign dash    = dur_x > CmpWidth'(dot_max_q);

  // Per-sample state update and event selection
  always_comb begin
    was_down_d = was_down_q;
    press_d    = press_q;
    gap_d      = gap_q;
    bits_d     = bits_q;
    held_d     = held_q;
    ovf_d      = ovf_q;
    push_o     = 1'b0;
    ev_o       = '0;
    if (accept) begin
      if (key_level_i) begin
        // press in progress
        press_d    = !was_down_q ? COUNT_WIDTH'(1)
                   : (press_q < CntMax) ? press_q + 1'b1 : press_q;
        was_down_d = 1'b1;
      end else if (was_down_q) begin
        // release: classify the press
        was_down_d = 1'b0;
        press_d    = '0;
        gap_d      = '0;
        push_o     = 1'b1;
        if (dur_x > CmpWidth'(long_press_q)) begin
          bits_d  = '0;
          held_d  = '0;
          ovf_d   = 1'b0;
          ev_o.kind = EV_TOO_LONG;
        end else begin
          if (held_q < HeldWidth'(MaxSymbols)) begin
            bits_d = bits_q | (MaxSymbols'(dash) << held_q[1:0]);
            held_d = held_q + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
          ev_o.kind  = EV_SYMBOL;
          ev_o.dash  = dash;
          ev_o.count = held_d;
        end
      end else if (held_q != '0) begin
        // idle with code held: count the gap, decode past the limit
        if (gap_x > CmpWidth'(gap_ticks_q)) begin
          push_o    = 1'b1;
          ev_o.kind = EV_LETTER;
          ev_o.held = held_q;
          ev_o.bits = bits_q;
          ev_o.ovf  = ovf_q;
          bits_d    = '0;
          held_d    = '0;
          ovf_d     = 1'b0;
          gap_d     = '0;
        end else begin
          gap_d = gap_inc;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      was_down_q <= 1'b0;
      press_q    <= '0;
      gap_q      <= '0;
      bits_q     <= '0;
      held_q     <= '0;
      ovf_q      <= 1'b0;
    end else begin
      was_down_q <= was_down_d;
      press_q    <= press_d;
      gap_q      <= gap_d;
      bits_q     <= bits_d;
      held_q     <= held_d;
      ovf_q      <= ovf_d;
    end
  end

endmodule

// ----- hdl/mkd_queue.sv -----
// Small event queue decoupling the front end from the result stage
module mkd_queue import mkd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  mkd_ev_t push_data_i,
  input  logic    pop_i,
  output mkd_ev_t head_o,
  output logic    empty_o,
  output logic    full_o
);

  mkd_ev_t              slot_q [QueueDepth];
  logic [QPtrWidth-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntWidth-1:0] count_q;
  logic                 do_push, do_pop;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == QCntWidth'(QueueDepth));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = slot_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: ;
      endcase
    end
  end

endmodule

// ----- hdl/mkd_back.sv -----
// Back end: letter lookup and output register
module mkd_back import mkd_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   q_empty_i,
  input  mkd_ev_t                head_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [KindWidth-1:0]   event_kind_o,
  output logic                   symbol_is_dash_o,
  output logic [LetterWidth-1:0] letter_index_o,
  output logic [HeldWidth-1:0]   symbol_count_o
);

  logic                   out_valid_q;
  logic [KindWidth-1:0]   kind_q, kind_d;
  logic                   dash_q;
  logic [LetterWidth-1:0] letter_q, letter_d;
  logic [HeldWidth-1:0]   count_q;
  logic                   found;
  logic [LetterWidth-1:0] match_idx;
  logic [6:0]             key_code;

  assign pop_o    = !q_empty_i && (!out_valid_q || out_ready_i);
  assign key_code = {head_i.held, head_i.bits};

  // Parallel match against the letter table
  always_comb begin
    found     = 1'b0;
    match_idx = '0;
    for (int i = 0; i < NumLetters; i++) begin
      if (LETTER_CODE[i] == key_code) begin
        found     = 1'b1;
        match_idx = LetterWidth'(i);
      end
    end
  end

  // Final event kind and letter
  always_comb begin
    kind_d   = head_i.kind;
    letter_d = '0;
    if (head_i.kind == EV_LETTER) begin
      if (found && !head_i.ovf) begin
        letter_d = match_idx;
      end else begin
        kind_d = EV_UNKNOWN;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      kind_q   <= kind_d;
      dash_q   <= head_i.dash;
      letter_q <= letter_d;
      count_q  <= head_i.count;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign event_kind_o     = kind_q;
  assign symbol_is_dash_o = dash_q;
  assign letter_index_o   = letter_q;
  assign symbol_count_o   = count_q;

endmodule

// ----- hdl/morse_key_decoder_core.sv -----
// Path: each event is registered in a queue slot, then in the output register; while the
// output register is stalled, events wait in the queue.
// Throughput: one key sample per cycle; the front stalls only when the 4-entry event
// queue between front end and output register is full.
// Reset (rst_ni, async, active low): timing state and held code cleared, queue empty,
// output invalid; registers return to dot 249, long press 700, gap 700 ticks.
module morse_key_decoder_core import mkd_pkg::*; #(
  parameter int COUNT_WIDTH = DefCountWidth
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   key_level_i,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxWidth-1:0] cfg_index_i,
  input  logic [CfgWidth-1:0]    cfg_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [KindWidth-1:0]   event_kind_o,
  output logic                   symbol_is_dash_o,
  output logic [LetterWidth-1:0] letter_index_o,
  output logic [HeldWidth-1:0]   symbol_count_o
);

  mkd_ev_t push_ev, head_ev;
  logic    push, pop, q_full, q_empty;

  mkd_front #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .key_level_i(key_level_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .ev_o       (push_ev)
  );

  mkd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_ev),
    .pop_i      (pop),
    .head_o     (head_ev),
    .empty_o    (q_empty),
    .full_o     (q_full)
  );

  mkd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_empty_i       (q_empty),
    .head_i          (head_ev),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .event_kind_o    (event_kind_o),
    .symbol_is_dash_o(symbol_is_dash_o),
    .letter_index_o  (letter_index_o),
    .symbol_count_o  (symbol_count_o)
  );

endmodule

// ----- hdl/mkd_checker.sv -----
// Port-level checker for the Morse key decoder, bound to the top level
`include "morse_key_decoder_core_assert.svh"
module mkd_checker import mkd_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input logic [KindWidth-1:0]   event_kind_o,
  input logic                   symbol_is_dash_o,
  input logic [LetterWidth-1:0] letter_index_o,
  input logic [HeldWidth-1:0]   symbol_count_o
);

  // A stalled result holds
  `MKD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(event_kind_o) && $stable(letter_index_o) && $stable(symbol_count_o), "stalled result changed")
  // Only symbol events carry a dash or a nonzero symbol count
  `MKD_ASSERT_NOW(a_dash_only_symbol, clk_i, rst_ni, out_valid_o && event_kind_o != EV_SYMBOL, !symbol_is_dash_o && symbol_count_o == '0, "non-symbol event with dash or symbols held")
  // Letters stay in range, and appear only on letter events
  `MKD_ASSERT_NOW(a_letter_range, clk_i, rst_ni, out_valid_o, (letter_index_o <= LetterWidth'(NumLetters - 1)) && (event_kind_o == EV_LETTER || letter_index_o == '0), "bad letter index")
  // A symbol event always holds between one and four symbols
  `MKD_ASSERT_NOW(a_symbol_count, clk_i, rst_ni, out_valid_o && event_kind_o == EV_SYMBOL, symbol_count_o != '0 && symbol_count_o <= HeldWidth'(MaxSymbols), "symbol count out of range")

endmodule

bind morse_key_decoder_core mkd_checker u_mkd_checker (.*);

// ----- test/testbench.sv -----
// Testbench for the Morse key decoder core: directed key table, then randomized keying
`timescale 1ns / 1ps

module testbench;
  import mkd_pkg::*;

  localparam int CountW = 10;
  localparam logic [CountW-1:0] CountMax = '1;
  localparam logic [CfgIdxWidth-1:0] RegUnused = 2'd3;
  localparam int CycleLimit = 4_000_000;
  localparam int RandomSamples = 1000;
  localparam int MinRandomEvents = 48;
  localparam int MinPhases = 8;
  localparam int PhaseSamples = 150;
  localparam int HoldCycles = 300;
  localparam int DrainCycles = 8;
  localparam logic [LetterWidth-1:0] LetterA = 5'd0;
  localparam logic [LetterWidth-1:0] LetterH = 5'd7;
  localparam logic [LetterWidth-1:0] LetterT = 5'd19;

  typedef struct packed {
    logic [KindWidth-1:0]   kind;
    logic                   dash;
    logic [LetterWidth-1:0] letter;
    logic [HeldWidth-1:0]   count;
  } key_event_t;

  localparam key_event_t NoEvent = '0;

  typedef enum logic [1:0] {ROW_KEY, ROW_PULSES, ROW_CFG} row_kind_e;
  typedef enum {PRESS_DOT, PRESS_DASH, PRESS_TOO_LONG} press_kind_e;

  // One row: a run of key samples, a train of presses, or a register write
  typedef struct packed {
    row_kind_e              kind;
    logic                   level;
    logic [3:0]             reps;
    logic [10:0]            ticks;
    logic [CfgIdxWidth-1:0] idx;
    logic [CfgWidth-1:0]    value;
    logic                   typed;
    key_event_t             want;
  } plan_row_t;

  localparam int NumRows = 34;
  localparam plan_row_t KeyPlan [NumRows] = '{
    // reset values: dot 249, long press 700, gap 700
    '{ROW_KEY, 1'b0, 4'd0, 11'd4, REG_DOT_MAX, 10'd0, 1'b0, NoEvent},
    '{ROW_KEY, 1'b1, 4'd0, 11'd249, REG_DOT_MAX, 10'd0, 1'b0, NoEvent},
    '{ROW_KEY, 1'b0, 4'd0, 11'd1, REG_DOT_MAX, 10'd0, 1'b1, '{EV_SYMBOL, 1'b0, 5'd0, 3'd1}},
    // one tick over the dot limit is a dash
    '{ROW_KEY, 1'b1, 4'd0, 11'd250, REG_DOT_MAX, 10'd0, 1'b0, NoEvent},
    '{ROW_KEY, 1'b0, 4'd0, 11'd1, REG_DOT_MAX, 10'd0, 1'b1, '{EV_SYMBOL, 1'b1, 5'd0, 3'd2}},
    '{ROW_KEY, 1'b0, 4'd0, 11'd700, REG_DOT_MAX, 10'd0, 1'b0, NoEvent},
    '{ROW_KEY, 1'b0, 4'd0, 11'd1, REG_DOT_MAX, 10'd0, 1'b1, '{EV_LETTER, 1'b0, LetterA, 3'd0}},
    // held dot, then a press one tick over the long limit clears it
    '{ROW_KEY, 1'b1, 4'd0, 11'd1, REG_DOT_MAX, 10'd0, 1'b0, NoEvent},
    '{ROW_KEY, 1'b0, 4'd0, 11'd1, REG_DOT_MAX, 10'd0, 1'b1, '{EV_SYMBOL, 1'b0, 5'd0, 3'd1}},
    '{ROW_KEY, 1'b1, 4'd0, 11'd701, REG_DOT_MAX, 10'd0, 1'b0, NoEvent},
    '{ROW_KEY, 1'b0, 4'd0, 11'd1, REG_DOT_MAX, 10'd0, 1'b1, '{EV_TOO_LONG, 1'b0, 5'd0, 3'd0}},
    '{ROW_KEY, 1'b0, 4'd0, 11'd4, REG_DOT_MAX, 10'd0, 1'b0, NoEvent},
    // long press limit at its top: a saturated press is a plain dash
    '{ROW_CFG, 1'b0, 4'd0, 11'd0, REG_DOT_MAX, 10'd2, 1'b0, NoEvent},
    '{ROW_CFG, 1'b0, 4'd0, 11'd0, REG_LONG_PRESS, 10'd1023, 1'b0, NoEvent},
    '{ROW_CFG, 1'b0, 4'd0, 11'd0, REG_GAP, 10'd0, 1'b0, NoEvent},
    '{ROW_KEY, 1'b1, 4'd0, 11'd1025, REG_DOT_MAX, 10'd0, 1'b0, NoEvent},
    '{ROW_KEY, 1'b0, 4'd0, 11'd1, REG_DOT_MAX, 10'd0, 1'b1, '{EV_SYMBOL, 1'b1, 5'd0, 3'd1}},
    '{ROW_KEY, 1'b0, 4'd0, 11'd1, REG_DOT_MAX, 10'd0, 1'b1, '{EV_LETTER, 1'b0, LetterT, 3'd0}},
    // five dots back to back overflow the code
    '{ROW_PULSES, 1'b1, 4'd5, 11'd1, REG_DOT_MAX, 10'd0, 1'b0, NoEvent},
    '{ROW_KEY, 1'b0, 4'd0, 11'd1, REG_DOT_MAX, 10'd0, 1'b1, '{EV_UNKNOWN, 1'b0, 5'd0, 3'd0}},
    // zero long press limit: every press is too long
    '{ROW_CFG, 1'b0, 4'd0, 11'd0, REG_LONG_PRESS, 10'd0, 1'b0, NoEvent},
    '{ROW_KEY, 1'b1, 4'd0, 11'd1, REG_DOT_MAX, 10'd0, 1'b0, NoEvent},
    '{ROW_KEY, 1'b0, 4'd0, 11'd1, REG_DOT_MAX, 10'd0, 1'b1, '{EV_TOO_LONG, 1'b0, 5'd0, 3'd0}},
    // zero dot limit: all dashes; unused index must be ignored
    '{ROW_CFG, 1'b0, 4'd0, 11'd0, REG_DOT_MAX, 10'd0, 1'b0, NoEvent},
    '{ROW_CFG, 1'b0, 4'd0, 11'd0, REG_LONG_PRESS, 10'd5, 1'b0, NoEvent},
    '{ROW_CFG, 1'b0, 4'd0, 11'd0, REG_GAP, 10'd2, 1'b0, NoEvent},
    '{ROW_CFG, 1'b0, 4'd0, 11'd0, RegUnused, 10'd1023, 1'b0, NoEvent},
    '{ROW_PULSES, 1'b1, 4'd4, 11'd5, REG_DOT_MAX, 10'd0, 1'b0, NoEvent},
    '{ROW_KEY, 1'b0, 4'd0, 11'd3, REG_DOT_MAX, 10'd0, 1'b1, '{EV_UNKNOWN, 1'b0, 5'd0, 3'd0}},
    // dot limit at its top: all dots
    '{ROW_CFG, 1'b0, 4'd0, 11'd0, REG_DOT_MAX, 10'd1023, 1'b0, NoEvent},
    '{ROW_PULSES, 1'b1, 4'd4, 11'd3, REG_DOT_MAX, 10'd0, 1'b0, NoEvent},
    '{ROW_KEY, 1'b0, 4'd0, 11'd3, REG_DOT_MAX, 10'd0, 1'b1, '{EV_LETTER, 1'b0, LetterH, 3'd0}},
    '{ROW_KEY, 1'b1, 4'd0, 11'd6, REG_DOT_MAX, 10'd0, 1'b0, NoEvent},
    '{ROW_KEY, 1'b0, 4'd0, 11'd1, REG_DOT_MAX, 10'd0, 1'b1, '{EV_TOO_LONG, 1'b0, 5'd0, 3'd0}}
  };

  // International Morse alphabet, A to Z
  string morse_tab [NumLetters] = '{
    ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
    "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
    "..-", "...-", ".--", "-..-", "-.--", "--.."
  };

  logic                   clk_i;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_ready_o;
  logic                   key_level_i;
  logic                   cfg_we_i;
  logic [CfgIdxWidth-1:0] cfg_index_i;
  logic [CfgWidth-1:0]    cfg_data_i;
  logic                   out_valid_o;
  logic                   out_ready_i;
  logic [KindWidth-1:0]   event_kind_o;
  logic                   symbol_is_dash_o;
  logic [LetterWidth-1:0] letter_index_o;
  logic [HeldWidth-1:0]   symbol_count_o;

  morse_key_decoder_core #(
    .COUNT_WIDTH(CountW)
  ) DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .key_level_i      (key_level_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .event_kind_o     (event_kind_o),
    .symbol_is_dash_o (symbol_is_dash_o),
    .letter_index_o   (letter_index_o),
    .symbol_count_o   (symbol_count_o)
  );

  // Decoder state as the block should hold it
  logic [CfgWidth-1:0]    dot_limit, long_limit, gap_limit;
  logic                   key_down;
  logic [CountW-1:0]      press_len, idle_len;
  logic [MaxSymbols-1:0]  code_bits;
  logic [HeldWidth-1:0]   code_len;
  logic                   code_ovf;

  key_event_t pending_events [$];
  int  errors;
  int  samples_sent;
  int  events_due;
  int  cycle_count;
  bit  steady;
  bit  hold_req;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic void clear_code();
    code_bits = '0;
    code_len  = '0;
    code_ovf  = 1'b0;
    idle_len  = '0;
  endfunction

  function automatic void reset_decoder();
    // register reset values: dot 249, long press 700, gap 700
    dot_limit  = 10'd249;
    long_limit = 10'd700;
    gap_limit  = 10'd700;
    key_down   = 1'b0;
    press_len  = '0;
    clear_code();
  endfunction

  function automatic void apply_reg(logic [CfgIdxWidth-1:0] idx, logic [CfgWidth-1:0] value);
    case (idx)
      REG_DOT_MAX:    dot_limit  = value;
      REG_LONG_PRESS: long_limit = value;
      REG_GAP:        gap_limit  = value;
      default: ;
    endcase
  endfunction

  // Advance the decoder by one key sample; returns 1 when an event results
  function automatic bit key_tick(input logic level, output key_event_t ev);
    logic [CountW-1:0] dur;
    bit hit;
    int i, j;
    ev = '0;
    if (level) begin
      if (!key_down) press_len = CountW'(1);
      else if (press_len != CountMax) press_len = press_len + 1'b1;
      key_down = 1'b1;
      return 1'b0;
    end
    // release: classify the press
    if (key_down) begin
      dur = press_len;
      key_down  = 1'b0;
      press_len = '0;
      idle_len  = '0;
      if (dur > long_limit) begin
        clear_code();
        ev.kind = EV_TOO_LONG;
        return 1'b1;
      end
      ev.dash = (dur > dot_limit);
      if (code_len < MaxSymbols) begin
        code_bits[code_len[1:0]] = ev.dash;
        code_len = code_len + 1'b1;
      end else begin
        code_ovf = 1'b1;
      end
      ev.kind  = EV_SYMBOL;
      ev.count = code_len;
      return 1'b1;
    end
    // idle: count the gap while a code is held
    if (code_len == 0) return 1'b0;
    if (idle_len != CountMax) idle_len = idle_len + 1'b1;
    if (idle_len <= gap_limit) return 1'b0;
    ev.kind = EV_UNKNOWN;
    if (!code_ovf) begin
      for (i = 0; i < NumLetters; i++) begin
        hit = (morse_tab[i].len() == code_len);
        for (j = 0; j < code_len; j++)
          if (hit && ((morse_tab[i][j] == "-") != code_bits[j])) hit = 1'b0;
        if (hit) begin
          ev.kind   = EV_LETTER;
          ev.letter = LetterWidth'(i);
        end
      end
    end
    clear_code();
    return 1'b1;
  endfunction

  // Mostly no gap, often a short one, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Press length for a wanted symbol, biased to the classification edges
  function automatic int press_ticks(press_kind_e k);
    int lo, hi;
    lo = 1;
    hi = (dot_limit < long_limit) ? int'(dot_limit) : int'(long_limit);
    if (k == PRESS_DASH && dot_limit < long_limit) begin
      lo = int'(dot_limit) + 1;
      hi = int'(long_limit);
    end else if (k == PRESS_TOO_LONG) begin
      lo = int'(long_limit) + 1;
      hi = lo + 2;
    end
    if (hi < lo) hi = lo;
    if ($urandom_range(0, 3) == 0) return hi;
    return lo + $urandom_range(0, (hi - lo < 4) ? hi - lo : 4);
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      errors++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  // One key sample transfer; a typed expectation replaces the predicted one
  task automatic send_key(input logic level, input bit typed, input key_event_t want);
    key_event_t ev;
    int n;
    n = steady ? 0 : pick_gap();
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    key_level_i <= level;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    samples_sent++;
    if (key_tick(level, ev)) begin
      pending_events.push_back(typed ? want : ev);
      events_due++;
    end
  endtask

  task automatic send_run(input logic level, input int n);
    repeat (n) send_key(level, 1'b0, NoEvent);
  endtask

  // Wait until every expected event is out and the pipeline has drained
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxWidth-1:0] idx, input logic [CfgWidth-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    apply_reg(idx, value);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic configure_phase(input int phase);
    int dot, lng, gap;
    case (phase)
      0: begin dot = 3;    lng = 8;  gap = 4;    end
      1: begin dot = 2;    lng = 5;  gap = 2;    end
      2: begin dot = 1023; lng = 30; gap = 0;    end
      3: begin dot = 0;    lng = 4;  gap = 1;    end
      4: begin dot = 2;    lng = 0;  gap = 3;    end
      5: begin dot = 2;    lng = 6;  gap = 1023; end
      default: begin
        dot = $urandom_range(1, 6);
        lng = dot + $urandom_range(0, 10);
        gap = $urandom_range(0, 8);
      end
    endcase
    write_reg(REG_DOT_MAX, CfgWidth'(dot));
    write_reg(REG_LONG_PRESS, CfgWidth'(lng));
    write_reg(REG_GAP, CfgWidth'(gap));
    if ($urandom_range(0, 2) == 0) write_reg(RegUnused, CfgWidth'($urandom_range(0, 1023)));
  endtask

  // One letter (or a random code of up to five symbols) followed by a decode gap
  task automatic send_code();
    bit [4:0] dashes;
    int nsym, j, extra;
    string s;
    press_kind_e k;
    if ($urandom_range(0, 3) != 0) begin
      s = morse_tab[$urandom_range(0, NumLetters - 1)];
      nsym = s.len();
      for (j = 0; j < nsym; j++) dashes[j] = (s[j] == "-");
    end else begin
      nsym = $urandom_range(1, 5);
      dashes = 5'($urandom_range(0, 31));
    end
    for (j = 0; j < nsym; j++) begin
      if ($urandom_range(0, 11) == 0) k = PRESS_TOO_LONG;
      else k = dashes[j] ? PRESS_DASH : PRESS_DOT;
      send_run(1'b1, press_ticks(k));
      send_run(1'b0, 1);
      // inter-symbol space stays within the gap limit
      if (j < nsym - 1) begin
        if ($urandom_range(0, 3) == 0) extra = int'(gap_limit);
        else extra = $urandom_range(0, (gap_limit < 3) ? int'(gap_limit) : 3);
        send_run(1'b0, extra);
      end
    end
    send_run(1'b0, int'(gap_limit) + 1 + $urandom_range(0, 2));
  endtask

  // Output side: ready in random stretches, one long hold on request
  initial begin : receiver
    int run, stall;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else begin
        run = $urandom_range(1, 40);
        out_ready_i <= 1'b1;
        repeat (run) @(posedge clk_i);
        stall = pick_gap();
        if (stall > 0) begin
          out_ready_i <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
    end
  end

  // Compare each event transfer with the oldest expectation
  always @(posedge clk_i) begin : scoreboard
    key_event_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_events.size() == 0) begin
        errors++;
        $error("event_kind: expected no event, got %0d", event_kind_o);
      end else begin
        want = pending_events.pop_front();
        check_field("event_kind", want.kind, event_kind_o);
        check_field("symbol_is_dash", want.dash, symbol_is_dash_o);
        check_field("letter_index", want.letter, letter_index_o);
        check_field("symbol_count", want.count, symbol_count_o);
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin : stimulus
    int r, phase, phase_start, rand_samples, rand_events;
    errors = 0;
    samples_sent = 0;
    events_due = 0;
    cycle_count = 0;
    steady = 1'b0;
    hold_req = 1'b0;
    reset_decoder();
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    key_level_i <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_index_i <= REG_DOT_MAX;
    cfg_data_i  <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    for (r = 0; r < NumRows; r++) begin
      case (KeyPlan[r].kind)
        ROW_CFG: begin
          settle();
          write_reg(KeyPlan[r].idx, KeyPlan[r].value);
        end
        ROW_PULSES: begin
          repeat (KeyPlan[r].reps) begin
            send_run(1'b1, KeyPlan[r].ticks);
            send_run(1'b0, 1);
          end
        end
        default: begin
          repeat (KeyPlan[r].ticks)
            send_key(KeyPlan[r].level, KeyPlan[r].typed, KeyPlan[r].want);
        end
      endcase
    end

    // random phases, each under its own register setting
    rand_samples = samples_sent;
    rand_events  = events_due;
    phase = 0;
    while (phase < MinPhases || samples_sent - rand_samples < RandomSamples ||
           events_due - rand_events < MinRandomEvents) begin
      settle();
      configure_phase(phase);
      if (phase == 1) hold_req = 1'b1;
      phase_start = samples_sent;
      while (samples_sent - phase_start < PhaseSamples) begin
        steady = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 5) == 0) begin
          // noise burst
          repeat ($urandom_range(1, 24)) send_key(1'($urandom_range(0, 1)), 1'b0, NoEvent);
        end else begin
          send_code();
        end
      end
      phase++;
    end

    settle();
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
